// File: design/ssc_pkg.sv
// Shared types and constants for the subarray sum counter.
// Holds the token that travels down the cell chain and the result word.
// No dependencies.
`default_nettype none

package ssc_pkg;

  localparam int KEY_W          = 32;
  localparam int VAL_W          = 16;
  localparam int CNT_OUT_W      = 32;
  localparam int DEF_MAX_LENGTH = 1024;

  // One sequence element on its way down the chain.
  typedef struct packed {
    logic             vld;       // token carries an element
    logic             last;      // element closes its sequence
    logic             done;      // prefix already recorded by some cell
    logic             ovf;       // an entry count saturated on the way
    logic             self_hit;  // prefix itself equals the target
    logic [KEY_W-1:0] rec_key;   // prefix to record
    logic [KEY_W-1:0] look_key;  // prefix minus target to look up
  } tok_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] count;
    logic                 last;
    logic                 ovf;
  } res_t;

endpackage

`default_nettype wire

// File: design/subarray_sum_count.sv
// Subarray sum counter: counts contiguous runs of a signed stream equal to a target.
// An input word reaches the output through the head register, one register per table
// cell and the output register. Throughput: one word per cycle, set by the
// cell chain that advances every cycle; a full skid stage pauses the whole chain.
// Reset (synchronous, rst_n low): target 0, prefix and run count 0, every table
// entry empty, no word in flight. Dependencies: ssc_pkg, ssc_head, ssc_cell, ssc_tail.
`default_nettype none

module subarray_sum_count #(
  parameter int MAX_LENGTH = ssc_pkg::DEF_MAX_LENGTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream, tdata: [15:0] value
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [ssc_pkg::VAL_W-1:0]         in_tdata,
  input  wire logic                              in_tlast,
  // target write, data: [31:0] target_sum
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [ssc_pkg::KEY_W-1:0]         cfg_data,
  // result stream, tdata: [31:0] run_count; tuser: [0] overflow
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  output      logic [ssc_pkg::CNT_OUT_W-1:0]     out_tdata,
  output      logic                              out_tlast,
  output      logic                              out_tuser
);

  // Entry counts saturate at 2*MAX_LENGTH-1.
  localparam int CNT_W = $clog2(2 * MAX_LENGTH);

  // Chain enable: the whole row shifts together while the skid has room.
  logic en;

  // Token and hit count between neighbors; index 0 is the head's output.
  ssc_pkg::tok_t    tok_chain [MAX_LENGTH+1];
  logic [CNT_W-1:0] hit_chain [MAX_LENGTH+1];

  assign in_tready    = en;
  assign cfg_ready    = 1'b1;
  assign hit_chain[0] = '0;

  // Head: accumulate the prefix, form the lookup key, launch one token a cycle while the chain is enabled.
  ssc_head u_head (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .tok_o     (tok_chain[0])
  );

  // Table cells: each holds one entry. Entries fill from cell 0 upward, so the
  // first empty cell a token meets is the lowest free entry. A token follows the
  // ones ahead of it down the chain, so it sees every earlier record in order.
  for (genvar i = 0; i < MAX_LENGTH; i++) begin : g_cell
    ssc_cell #(
      .MAX_LENGTH (MAX_LENGTH),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tok_i (tok_chain[i]),
      .hit_i (hit_chain[i]),
      .tok_o (tok_chain[i+1]),
      .hit_o (hit_chain[i+1])
    );
  end

  // Tail: add the lookup count, saturate, track overflow, drive the output.
  ssc_tail #(
    .CNT_W (CNT_W)
  ) u_tail (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_i      (tok_chain[MAX_LENGTH]),
    .hit_i      (hit_chain[MAX_LENGTH]),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// File: design/ssc_head.sv
// Head of the chain: target register, running prefix sum and token launch.
// Depends on ssc_pkg.
`default_nettype none

module ssc_head (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_tvalid,
  input  wire logic [ssc_pkg::VAL_W-1:0]     in_tdata,
  input  wire logic                          in_tlast,
  input  wire logic                          cfg_valid,
  input  wire logic [ssc_pkg::KEY_W-1:0]     cfg_data,
  output      ssc_pkg::tok_t                 tok_o
);

  logic [ssc_pkg::KEY_W-1:0] target_r;
  logic [ssc_pkg::KEY_W-1:0] prefix_r;
  logic [ssc_pkg::KEY_W-1:0] prefix_nxt;
  ssc_pkg::tok_t             tok_r;
  ssc_pkg::tok_t             tok_nxt;
  logic                      accept;

  assign accept = in_tvalid && en;

  always_comb begin
    prefix_nxt = prefix_r + {{(ssc_pkg::KEY_W-ssc_pkg::VAL_W){in_tdata[ssc_pkg::VAL_W-1]}},
                             in_tdata};
    tok_nxt.vld      = accept;
    tok_nxt.last     = in_tlast;
    tok_nxt.done     = 1'b0;
    tok_nxt.ovf      = 1'b0;
    tok_nxt.self_hit = (prefix_nxt == target_r);
    tok_nxt.rec_key  = prefix_nxt;
    tok_nxt.look_key = prefix_nxt - target_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= '0;
      prefix_r  <= '0;
      tok_r.vld <= 1'b0;
    end else begin
      if (cfg_valid) begin
        target_r <= cfg_data;
      end
      if (en) begin
        tok_r <= tok_nxt;
      end
      // drop the prefix after the closing element
      if (accept) begin
        prefix_r <= in_tlast ? '0 : prefix_nxt;
      end
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

// File: design/ssc_cell.sv
// One table entry of the prefix-sum chain: key, occurrence count, valid.
// Looks up and records the passing token, then hands it on. Depends on ssc_pkg.
`default_nettype none

module ssc_cell #(
  parameter int MAX_LENGTH = ssc_pkg::DEF_MAX_LENGTH,
  parameter int CNT_W      = $clog2(2 * MAX_LENGTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire ssc_pkg::tok_t    tok_i,
  input  wire logic [CNT_W-1:0] hit_i,
  output      ssc_pkg::tok_t    tok_o,
  output      logic [CNT_W-1:0] hit_o
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(2 * MAX_LENGTH - 1);

  logic                      vld_r, vld_nxt;
  logic [ssc_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  ssc_pkg::tok_t             tok_r, tok_nxt;
  logic [CNT_W-1:0]          hit_r, hit_nxt;
  logic                      look_hit;
  logic                      rec_hit;

  assign look_hit = vld_r && (key_r == tok_i.look_key);
  assign rec_hit  = vld_r && (key_r == tok_i.rec_key);

  always_comb begin
    vld_nxt = vld_r;
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    tok_nxt = tok_i;
    // lookup sees the count before this element's own record
    hit_nxt = look_hit ? cnt_r : hit_i;
    if (tok_i.vld && !tok_i.done) begin
      if (rec_hit) begin
        tok_nxt.done = 1'b1;
        if (cnt_r < CNT_MAX) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          tok_nxt.ovf = 1'b1;
        end
      end else if (!vld_r) begin
        tok_nxt.done = 1'b1;
        vld_nxt      = 1'b1;
        key_nxt      = tok_i.rec_key;
        cnt_nxt      = CNT_W'(1);
      end
    end
    // closing element empties the entry behind it
    if (tok_i.vld && tok_i.last) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
      key_r <= key_nxt;
      cnt_r <= cnt_nxt;
      tok_r <= tok_nxt;
      hit_r <= hit_nxt;
    end
  end

  assign tok_o = tok_r;
  assign hit_o = hit_r;

endmodule

`default_nettype wire

// File: design/ssc_tail.sv
// Tail of the chain: saturating run count, sticky overflow and output skid.
// Depends on ssc_pkg.
`default_nettype none

module ssc_tail #(
  parameter int CNT_W = $clog2(2 * ssc_pkg::DEF_MAX_LENGTH)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ssc_pkg::tok_t                     tok_i,
  input  wire logic [CNT_W-1:0]                  hit_i,
  output      logic                              en,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  output      logic [ssc_pkg::CNT_OUT_W-1:0]     out_tdata,
  output      logic                              out_tlast,
  output      logic                              out_tuser
);

  localparam int SUM_W = ssc_pkg::CNT_OUT_W + 1;

  logic [ssc_pkg::CNT_OUT_W-1:0] total_r;
  logic                          seq_ovf_r;
  logic                          out_vld_r;
  logic                          skid_vld_r;
  ssc_pkg::res_t                 out_res_r;
  ssc_pkg::res_t                 skid_res_r;
  ssc_pkg::res_t                 res_nxt;
  logic [SUM_W-1:0]              sum;
  logic                          load;

  assign en   = !skid_vld_r;
  assign load = tok_i.vld && en;

  always_comb begin
    sum = {1'b0, total_r} + SUM_W'(hit_i) + SUM_W'(tok_i.self_hit);
    res_nxt.count = sum[SUM_W-1] ? '1 : sum[ssc_pkg::CNT_OUT_W-1:0];
    res_nxt.last  = tok_i.last;
    // unrecorded prefix at the end means the table was full
    res_nxt.ovf   = seq_ovf_r || tok_i.ovf || !tok_i.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      seq_ovf_r  <= 1'b0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (load) begin
        total_r   <= tok_i.last ? '0 : res_nxt.count;
        seq_ovf_r <= tok_i.last ? 1'b0 : res_nxt.ovf;
      end
      if (out_vld_r && !out_tready) begin
        // hold the output word, park a new one in the skid
        if (load) begin
          skid_vld_r <= 1'b1;
          skid_res_r <= res_nxt;
        end
      end else if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        out_res_r  <= skid_res_r;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= load;
        if (load) begin
          out_res_r <= res_nxt;
        end
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_res_r.count;
  assign out_tlast  = out_res_r.last;
  assign out_tuser  = out_res_r.ovf;

endmodule

`default_nettype wire

// File: design/ssc_checker.sv
// Port-level checks for the subarray sum counter, bound to the top level.
// Depends on subarray_sum_count and ssc_pkg.
`default_nettype none

module ssc_props (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [ssc_pkg::CNT_OUT_W-1:0] out_tdata
);

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // input only stalls while a result word waits downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !$past(out_tready)))
    else $error("input stalled without a waiting result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output data changed while stalled");

endmodule

bind subarray_sum_count ssc_props u_ssc_props (.*);

`default_nettype wire
